// ===== rtl/bba_pkg.sv =====
// Shared constants and types for the block bitmap allocator.
package bba_pkg;

  localparam int FIELD_W    = 13;    // block number field width
  localparam int CNT_W      = 14;    // block count register width
  localparam int FIELD_SPAN = 8192;  // blocks addressable by a block field
  localparam int WORD_W     = 32;    // bitmap word width
  localparam int BIT_W      = 5;     // bit index inside a word
  localparam int GRP_W      = 16;    // words per summary group
  localparam int GSEL_W     = 4;     // index inside a group / group index
  localparam int NWORDS_MAX = FIELD_SPAN / WORD_W;  // 256 words, 16 groups

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== rtl/bba_ffz.sv =====
// Find-first-zero unit: lowest clear bit of a 32-bit vector.
module bba_ffz (
  input  logic [bba_pkg::WORD_W-1:0] vec,
  output logic                       found,
  output logic [bba_pkg::BIT_W-1:0]  idx
);
  import bba_pkg::*;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!vec[i]) begin
        found = 1'b1;
        idx   = BIT_W'(i);
      end
    end
  end

endmodule

// ===== rtl/bba_bitmap.sv =====
// Used-bit memory with per-word written flags and per-word full flags.
module bba_bitmap #(
  parameter int NW   = 256,
  parameter int WA_W = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bba_pkg::mem_ctl_t              ctl,
  input  logic [WA_W-1:0]                raddr,
  input  logic [WA_W-1:0]                waddr,
  input  logic [bba_pkg::WORD_W-1:0]     wdata,
  output logic [bba_pkg::WORD_W-1:0]     rdata,
  output logic [bba_pkg::NWORDS_MAX-1:0] full
);
  import bba_pkg::*;

  logic [WORD_W-1:0] mem [NW];
  logic [WORD_W-1:0] rd_word;
  logic              rd_valid;
  logic [NW-1:0]     valid;
  logic [NW-1:0]     full_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_word <= mem[raddr];
    end
  end

  // Unwritten words read as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      full_q   <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[waddr]  <= 1'b1;
        full_q[waddr] <= &wdata;
      end
      if (ctl.rd_en) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

  // Words past the end look full so the search never picks them.
  for (genvar i = 0; i < NWORDS_MAX; i++) begin : g_full
    if (i < NW) begin : g_real
      assign full[i] = full_q[i];
    end else begin : g_pad
      assign full[i] = 1'b1;
    end
  end

endmodule

// ===== rtl/block_bitmap_allocator_top.sv =====
// Top level of the first-fit block bitmap allocator.
//
// Usage: raise start with kind and block while busy is low; the request is
// taken at that clock edge and busy rises the next cycle. kind 0 allocates
// the lowest free block below the effective count (least of total_blocks,
// MAX_BLOCKS and 8192); kind 1 frees block. The answer appears on
// block_number and status, marked by done for exactly one cycle; the
// receiver cannot stall, so results must be taken as they come.
// Steps: an allocate passes S_GRP, S_WRD and S_BIT before done rises, a
// free passes S_FRD and S_BIT, and a free beyond the count or an allocate
// with every word full answers from S_FRD or S_GRP. busy drops in the done
// cycle, so no new request is taken before the done cycle.
// The sequencer drives one shared find-first-zero unit: it scans the group
// summary, then the group's word-full flags, then the bitmap word read from
// the bitmap memory, each step in its own state.
// Configuration: cfg_we writes cfg_wdata into total_blocks (reset 8192);
// write only while no request is in flight.
// Reset (rst, synchronous): every block is free, total_blocks is 8192,
// the sequencer idles. No clearing pass: per-word flags mark unwritten words.
module block_bitmap_allocator_top #(
  parameter int MAX_BLOCKS = 8192
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind,
  input  logic [bba_pkg::FIELD_W-1:0] block,
  input  logic                        cfg_we,
  input  logic [bba_pkg::CNT_W-1:0]   cfg_wdata,
  output logic                        done,
  output logic [bba_pkg::FIELD_W-1:0] block_number,
  output logic [1:0]                  status
);
  import bba_pkg::*;

  localparam int EFF_MAX = (MAX_BLOCKS < FIELD_SPAN) ? MAX_BLOCKS : FIELD_SPAN;
  localparam int NW      = (EFF_MAX + WORD_W - 1) / WORD_W;
  localparam int WA_W    = (NW > 1) ? $clog2(NW) : 1;
  localparam int NGRP    = NWORDS_MAX / GRP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRP,
    S_WRD,
    S_FRD,
    S_BIT
  } state_t;

  state_t               state;
  logic                 kind_q;
  logic [FIELD_W-1:0]   blk_q;
  logic [GSEL_W-1:0]    grp_q;
  logic [WA_W-1:0]      waddr_q;
  logic [CNT_W-1:0]     total_blocks;
  logic [CNT_W-1:0]     count;

  logic [NWORDS_MAX-1:0] full;
  logic [NGRP-1:0]       grp_full;
  logic [WORD_W-1:0]     ffz_vec;
  logic                  ffz_found;
  logic [BIT_W-1:0]      ffz_idx;
  logic [WORD_W-1:0]     rdata;
  logic [WORD_W-1:0]     wdata;
  logic [WA_W-1:0]       raddr;
  mem_ctl_t              mem_ctl;

  logic [GSEL_W+GSEL_W-1:0] word_sel;
  logic [FIELD_W-1:0]       alloc_blk;
  logic                     alloc_ok;
  logic                     free_in_range;
  logic                     free_bit;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= CNT_W'(FIELD_SPAN);
    end else if (cfg_we) begin
      total_blocks <= cfg_wdata;
    end
  end

  assign count = (total_blocks > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : total_blocks;
  assign busy  = (state != S_IDLE);

  for (genvar g = 0; g < NGRP; g++) begin : g_sum
    assign grp_full[g] = &full[g*GRP_W +: GRP_W];
  end

  // Feed the shared search unit according to the step.
  always_comb begin
    case (state)
      S_GRP:   ffz_vec = {{(WORD_W-NGRP){1'b1}}, grp_full};
      S_WRD:   ffz_vec = {{(WORD_W-GRP_W){1'b1}}, full[grp_q*GRP_W +: GRP_W]};
      default: ffz_vec = rdata;
    endcase
  end

  bba_ffz u_ffz (
    .vec   (ffz_vec),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  assign word_sel      = {grp_q, ffz_idx[GSEL_W-1:0]};
  assign alloc_blk     = FIELD_W'({waddr_q, ffz_idx});
  // A free bit at or past the count means nothing below it is free.
  assign alloc_ok      = ffz_found && ({1'b0, alloc_blk} < count);
  assign free_in_range = ({1'b0, blk_q} < count);
  assign free_bit      = rdata[blk_q[BIT_W-1:0]];

  assign raddr = (state == S_WRD) ? WA_W'(word_sel) : WA_W'(blk_q[FIELD_W-1:BIT_W]);

  always_comb begin
    mem_ctl.rd_en = (state == S_WRD) || ((state == S_FRD) && free_in_range);
    mem_ctl.wr_en = 1'b0;
    wdata         = rdata;
    if (state == S_BIT) begin
      if (kind_q == KIND_ALLOC) begin
        mem_ctl.wr_en = alloc_ok;
        wdata         = rdata | (WORD_W'(1) << ffz_idx);
      end else begin
        mem_ctl.wr_en = free_bit;
        wdata         = rdata & ~(WORD_W'(1) << blk_q[BIT_W-1:0]);
      end
    end
  end

  bba_bitmap #(
    .NW   (NW),
    .WA_W (WA_W)
  ) u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .raddr (raddr),
    .waddr (waddr_q),
    .wdata (wdata),
    .rdata (rdata),
    .full  (full)
  );

  // Sequencer: state and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      block_number <= '0;
      status       <= ST_OK;
      kind_q       <= KIND_ALLOC;
      blk_q        <= '0;
      grp_q        <= '0;
      waddr_q      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            kind_q <= kind;
            blk_q  <= block;
            state  <= (kind == KIND_ALLOC) ? S_GRP : S_FRD;
          end
        end
        S_GRP: begin
          // Pick the first group with a free word.
          grp_q <= ffz_idx[GSEL_W-1:0];
          if (ffz_found) begin
            state <= S_WRD;
          end else begin
            done         <= 1'b1;
            block_number <= '0;
            status       <= ST_FULL;
            state        <= S_IDLE;
          end
        end
        S_WRD: begin
          // Word with a free bit is read this cycle.
          waddr_q <= WA_W'(word_sel);
          state   <= S_BIT;
        end
        S_FRD: begin
          waddr_q <= WA_W'(blk_q[FIELD_W-1:BIT_W]);
          if (free_in_range) begin
            state <= S_BIT;
          end else begin
            done         <= 1'b1;
            block_number <= '0;
            status       <= ST_BADFREE;
            state        <= S_IDLE;
          end
        end
        S_BIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (kind_q == KIND_ALLOC) begin
            block_number <= alloc_ok ? alloc_blk : '0;
            status       <= alloc_ok ? ST_OK : ST_FULL;
          end else begin
            block_number <= '0;
            status       <= free_bit ? ST_OK : ST_BADFREE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while sequencer still busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (block_number == '0))
    else $error("nonzero block number on a failed request");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OK) && (kind_q == KIND_ALLOC) |-> ({1'b0, block_number} < count))
    else $error("allocated block at or past the count");

endmodule
